### sv/mfs_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the multilevel feedback scheduler.
// No dependencies; every other file imports this package.
package mfs_pkg;

    localparam int MAX_JOBS_DEF = 16;
    localparam logic [15:0] QUANTUM_RESET = 16'd4;

    localparam logic OP_SUBMIT   = 1'b0;
    localparam logic OP_DISPATCH = 1'b1;

    localparam logic [1:0] STATUS_DONE   = 2'd0;
    localparam logic [1:0] STATUS_REJECT = 2'd1;
    localparam logic [1:0] STATUS_EMPTY  = 2'd2;

    localparam logic LEVEL_RR  = 1'b0;
    localparam logic LEVEL_SJF = 1'b1;

    // One stored job: identifier and remaining run time.
    typedef struct packed {
        logic [7:0]  id;
        logic [15:0] rem;
    } job_t;

    typedef struct packed {
        logic        op;
        logic [7:0]  job_id;
        logic [15:0] burst;
    } sched_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  run_id;
        logic        level;
        logic [31:0] start_time;
        logic [15:0] run_length;
        logic        finished;
        logic [31:0] end_time;
    } sched_out_t;

endpackage

### sv/mfs_job_ram.sv
`timescale 1ns / 1ps
// Job memory: one write port, one read port, registered read data.
// Depends on mfs_pkg for job_t.
module mfs_job_ram
    import mfs_pkg::*;
#(
    parameter int DEPTH = MAX_JOBS_DEF
)(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  job_t                     wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output job_t                     rdata
);

    job_t mem [DEPTH];
    job_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### sv/multilevel_feedback_scheduler.sv
`timescale 1ns / 1ps
// Two-level feedback scheduler: round-robin FIFO in front of a shortest-job store.
// Result strobe (done) rises in the cycle after the deciding cycle; compaction may still run then.
// Submit: busy stays low, one item per cycle. Round-robin dispatch: registered FIFO head read.
// Shortest-job dispatch: S_SCAN reads the stored jobs in turn through the store's single read
// port, then S_SHIFT compacts the store behind the chosen entry when it is not the last one.
// Reset (rst_n, async low) empties both levels, zeroes time, sets quantum to 4; no clearing pass.
module multilevel_feedback_scheduler
    import mfs_pkg::*;
#(
    parameter int MAX_JOBS = MAX_JOBS_DEF
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  sched_in_t   cmd,
    output logic        busy,
    output logic        done,
    output sched_out_t  result,
    input  logic        cfg_we,
    input  logic [15:0] cfg_data
);

    localparam int IW = $clog2(MAX_JOBS);
    localparam int CW = $clog2(MAX_JOBS + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RR_WAIT,
        S_SCAN,
        S_SHIFT
    } state_t;

    state_t        state_reg, state_next;
    logic [15:0]   quantum_reg;
    logic [31:0]   now_reg, now_next;
    logic [IW-1:0] rr_head_reg, rr_head_next;
    logic [CW-1:0] rr_count_reg, rr_count_next;
    logic [CW-1:0] sjf_count_reg, sjf_count_next;
    logic [IW-1:0] scan_idx_reg, scan_idx_next;
    logic [IW-1:0] pend_idx_reg, pend_idx_next;
    logic [IW-1:0] best_idx_reg, best_idx_next;
    job_t          best_job_reg, best_job_next;
    logic [IW-1:0] wr_idx_reg, wr_idx_next;
    logic          done_reg, done_next;
    sched_out_t    result_reg, result_next;

    // Memory ports
    logic          rr_we;
    logic [IW-1:0] rr_waddr;
    job_t          rr_wdata;
    job_t          rr_rdata;
    logic          sjf_we;
    logic [IW-1:0] sjf_waddr;
    job_t          sjf_wdata;
    logic [IW-1:0] sjf_raddr;
    job_t          sjf_rdata;

    // Datapath helpers
    logic          full;
    logic [CW:0]   tail_sum;
    logic [IW-1:0] tail_idx;
    logic [IW-1:0] head_inc;
    logic          take;
    logic          scan_last;

    // Build a dispatch result and the new saturating time.
    function automatic sched_out_t make_report(input logic [31:0] t, input logic [7:0] id,
                                               input logic lvl, input logic [15:0] len,
                                               input logic fin);
        sched_out_t  r;
        logic [32:0] sum;
        begin
            sum          = {1'b0, t} + {17'd0, len};
            r.status     = STATUS_DONE;
            r.run_id     = id;
            r.level      = lvl;
            r.start_time = t;
            r.run_length = len;
            r.finished   = fin;
            r.end_time   = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            return r;
        end
    endfunction

    mfs_job_ram #(.DEPTH(MAX_JOBS)) u_rr_ram (
        .clk   (clk),
        .we    (rr_we),
        .waddr (rr_waddr),
        .wdata (rr_wdata),
        .raddr (rr_head_reg),
        .rdata (rr_rdata)
    );

    mfs_job_ram #(.DEPTH(MAX_JOBS)) u_sjf_ram (
        .clk   (clk),
        .we    (sjf_we),
        .waddr (sjf_waddr),
        .wdata (sjf_wdata),
        .raddr (sjf_raddr),
        .rdata (sjf_rdata)
    );

    // Both levels together hold at most MAX_JOBS jobs, so demotion always finds room.
    assign full     = ({1'b0, rr_count_reg} + {1'b0, sjf_count_reg}) >= (CW+1)'(MAX_JOBS);
    assign tail_sum = (CW+1)'(rr_head_reg) + (CW+1)'(rr_count_reg);
    assign tail_idx = (tail_sum >= (CW+1)'(MAX_JOBS)) ? IW'(tail_sum - (CW+1)'(MAX_JOBS))
                                                      : IW'(tail_sum);
    assign head_inc = (rr_head_reg == IW'(MAX_JOBS - 1)) ? '0 : rr_head_reg + IW'(1);

    // Minimum search: strict less-than keeps the earliest demoted job on ties.
    assign take      = (pend_idx_reg == '0) || (sjf_rdata.rem < best_job_reg.rem);
    assign scan_last = (CW'(pend_idx_reg) + CW'(1)) == sjf_count_reg;

    always_comb
    begin
        state_next     = state_reg;
        now_next       = now_reg;
        rr_head_next   = rr_head_reg;
        rr_count_next  = rr_count_reg;
        sjf_count_next = sjf_count_reg;
        scan_idx_next  = scan_idx_reg;
        pend_idx_next  = pend_idx_reg;
        best_idx_next  = best_idx_reg;
        best_job_next  = best_job_reg;
        wr_idx_next    = wr_idx_reg;
        done_next      = 1'b0;
        result_next    = result_reg;

        rr_we     = 1'b0;
        rr_waddr  = tail_idx;
        rr_wdata  = '{id: cmd.job_id, rem: cmd.burst};
        sjf_we    = 1'b0;
        sjf_waddr = wr_idx_reg;
        sjf_wdata = sjf_rdata;
        sjf_raddr = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (cmd.op == OP_SUBMIT)
                    begin
                        // Append at the FIFO tail, or reject when the levels are full.
                        done_next   = 1'b1;
                        result_next = '0;
                        if (full)
                        begin
                            result_next.status = STATUS_REJECT;
                        end
                        else
                        begin
                            rr_we         = 1'b1;
                            rr_count_next = rr_count_reg + CW'(1);
                        end
                    end
                    else if (rr_count_reg != '0)
                    begin
                        // Head read is already on the FIFO read port.
                        state_next = S_RR_WAIT;
                    end
                    else if (sjf_count_reg != '0)
                    begin
                        sjf_raddr     = '0;
                        pend_idx_next = '0;
                        scan_idx_next = IW'(1);
                        state_next    = S_SCAN;
                    end
                    else
                    begin
                        done_next          = 1'b1;
                        result_next        = '0;
                        result_next.status = STATUS_EMPTY;
                    end
                end
            end

            S_RR_WAIT:
            begin
                rr_head_next  = head_inc;
                rr_count_next = rr_count_reg - CW'(1);
                done_next     = 1'b1;
                if (rr_rdata.rem > quantum_reg)
                begin
                    // Run one quantum, then demote the remainder to the store's end.
                    if (sjf_count_reg < CW'(MAX_JOBS))
                    begin
                        sjf_we         = 1'b1;
                        sjf_waddr      = IW'(sjf_count_reg);
                        sjf_wdata      = '{id: rr_rdata.id, rem: rr_rdata.rem - quantum_reg};
                        sjf_count_next = sjf_count_reg + CW'(1);
                    end
                    result_next = make_report(now_reg, rr_rdata.id, LEVEL_RR, quantum_reg, 1'b0);
                end
                else
                begin
                    result_next = make_report(now_reg, rr_rdata.id, LEVEL_RR, rr_rdata.rem,
                                              1'b1);
                end
                now_next   = result_next.end_time;
                state_next = S_IDLE;
            end

            S_SCAN:
            begin
                if (take)
                begin
                    best_idx_next = pend_idx_reg;
                    best_job_next = sjf_rdata;
                end
                if (!scan_last)
                begin
                    // Issue the next read while comparing the one that just returned.
                    sjf_raddr     = scan_idx_reg;
                    pend_idx_next = scan_idx_reg;
                    scan_idx_next = scan_idx_reg + IW'(1);
                end
                else
                begin
                    done_next   = 1'b1;
                    result_next = make_report(now_reg, best_job_next.id, LEVEL_SJF,
                                              best_job_next.rem, 1'b1);
                    now_next    = result_next.end_time;
                    if ((CW'(best_idx_next) + CW'(1)) < sjf_count_reg)
                    begin
                        // Close the gap: move every later entry down by one.
                        sjf_raddr   = best_idx_next + IW'(1);
                        wr_idx_next = best_idx_next;
                        state_next  = S_SHIFT;
                    end
                    else
                    begin
                        sjf_count_next = sjf_count_reg - CW'(1);
                        state_next     = S_IDLE;
                    end
                end
            end

            S_SHIFT:
            begin
                sjf_we    = 1'b1;
                sjf_waddr = wr_idx_reg;
                sjf_wdata = sjf_rdata;
                if ((CW'(wr_idx_reg) + CW'(2)) < sjf_count_reg)
                begin
                    sjf_raddr   = wr_idx_reg + IW'(2);
                    wr_idx_next = wr_idx_reg + IW'(1);
                end
                else
                begin
                    sjf_count_next = sjf_count_reg - CW'(1);
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            quantum_reg   <= QUANTUM_RESET;
            now_reg       <= '0;
            rr_head_reg   <= '0;
            rr_count_reg  <= '0;
            sjf_count_reg <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            if (cfg_we)
            begin
                quantum_reg <= cfg_data;
            end
            now_reg       <= now_next;
            rr_head_reg   <= rr_head_next;
            rr_count_reg  <= rr_count_next;
            sjf_count_reg <= sjf_count_next;
            done_reg      <= done_next;
        end
    end

    // Payload and scan registers need no reset.
    always_ff @(posedge clk)
    begin
        scan_idx_reg <= scan_idx_next;
        pend_idx_reg <= pend_idx_next;
        best_idx_reg <= best_idx_next;
        best_job_reg <= best_job_next;
        wr_idx_reg   <= wr_idx_next;
        result_reg   <= result_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

### verif/schedule_checker.sv
`timescale 1ns / 1ps
// Checker for the multilevel feedback scheduler: watches the command, result and config ports.
// It predicts every result and compares it field by field. Depends on mfs_pkg.
module schedule_checker
    import mfs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic       busy,
    input  sched_in_t  cmd,
    input  logic       done,
    input  sched_out_t result,
    input  logic       cfg_we,
    input  logic [15:0] cfg_data,
    output int         errors,
    output int         checked,
    output int         pending
);

    job_t        rr_jobs[$];
    job_t        demoted_jobs[$];
    sched_out_t  due_results[$];
    logic [31:0] sched_now;
    logic [15:0] quantum;
    int          n_err;
    int          n_checked;

    function automatic logic [31:0] add_time(input logic [31:0] t, input logic [15:0] len);
        logic [32:0] sum;
        sum = {1'b0, t} + {17'd0, len};
        return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    endfunction

    // Advance the scheduler by one command and return the result it produces.
    function automatic sched_out_t schedule_item(input sched_in_t it);
        sched_out_t r;
        job_t       j;
        int         pick;
        bit         ran;
        r = '0;
        ran = 1'b0;
        if (it.op == OP_SUBMIT) begin
            if (rr_jobs.size() + demoted_jobs.size() >= MAX_JOBS_DEF) begin
                r.status = STATUS_REJECT;
            end
            else begin
                j.id = it.job_id;
                j.rem = it.burst;
                rr_jobs.push_back(j);
                r.status = STATUS_DONE;
            end
        end
        else if (rr_jobs.size() > 0) begin
            j = rr_jobs.pop_front();
            ran = 1'b1;
            r.level = LEVEL_RR;
            r.run_id = j.id;
            if (j.rem > quantum) begin
                r.run_length = quantum;
                r.finished = 1'b0;
                j.rem = j.rem - quantum;
                demoted_jobs.push_back(j);
            end
            else begin
                r.run_length = j.rem;
                r.finished = 1'b1;
            end
        end
        else if (demoted_jobs.size() > 0) begin
            // least remaining time; strict compare keeps the earliest demoted on a tie
            pick = 0;
            for (int k = 1; k < demoted_jobs.size(); k++)
                if (demoted_jobs[k].rem < demoted_jobs[pick].rem)
                    pick = k;
            j = demoted_jobs[pick];
            demoted_jobs.delete(pick);
            ran = 1'b1;
            r.level = LEVEL_SJF;
            r.run_id = j.id;
            r.run_length = j.rem;
            r.finished = 1'b1;
        end
        else begin
            r.status = STATUS_EMPTY;
        end
        if (ran) begin
            r.status = STATUS_DONE;
            r.start_time = sched_now;
            r.end_time = add_time(sched_now, r.run_length);
            sched_now = r.end_time;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (n_err < 40)
            $display("mismatch at %0t ns: %s got %0d expected %0d", $time, what, got, want);
        n_err++;
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    always @(posedge clk or negedge rst_n) begin
        sched_out_t want;
        if (!rst_n) begin
            rr_jobs.delete();
            demoted_jobs.delete();
            due_results.delete();
            sched_now = '0;
            quantum = QUANTUM_RESET;
            n_err = 0;
            n_checked = 0;
            errors <= 0;
            checked <= 0;
            pending <= 0;
        end
        else begin
            if (done === 1'b1) begin
                if (due_results.size() == 0) begin
                    report_mismatch("result with nothing due, status", 32'(result.status),
                                    32'd0);
                end
                else begin
                    want = due_results.pop_front();
                    check_field("status", 32'(result.status), 32'(want.status));
                    check_field("run_id", 32'(result.run_id), 32'(want.run_id));
                    check_field("level", 32'(result.level), 32'(want.level));
                    check_field("start_time", result.start_time, want.start_time);
                    check_field("run_length", 32'(result.run_length), 32'(want.run_length));
                    check_field("finished", 32'(result.finished), 32'(want.finished));
                    check_field("end_time", result.end_time, want.end_time);
                    n_checked++;
                end
            end
            if (cfg_we === 1'b1)
                quantum = cfg_data;
            if (start === 1'b1 && busy === 1'b0)
                due_results.push_back(schedule_item(cmd));
            errors <= n_err;
            checked <= n_checked;
            pending <= due_results.size();
        end
    end

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// Top of the scheduler testbench: clock, reset, command stimulus, quantum writes and verdict.
// Depends on mfs_pkg, multilevel_feedback_scheduler and schedule_checker.
module tb;
    import mfs_pkg::*;

    // Roomy bound: about 450 items with their busy time, idle gaps and settles stay well below it.
    localparam int CYCLE_LIMIT = 200_000;
    localparam int PHASE_ITEMS = 70;

    logic        clk;
    logic        rst_n;
    logic        start;
    sched_in_t   cmd;
    logic        busy;
    logic        done;
    sched_out_t  result;
    logic        cfg_we;
    logic [15:0] cfg_data;

    int          errors;
    int          checked;
    int          pending;
    int          cycles = 0;
    int          n_submit;
    int          n_dispatch;
    int          n_quanta;
    bit          calm;          // when set, never idle between items

    multilevel_feedback_scheduler dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .cmd      (cmd),
        .busy     (busy),
        .done     (done),
        .result   (result),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    schedule_checker checker_u (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .cmd      (cmd),
        .done     (done),
        .result   (result),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .errors   (errors),
        .checked  (checked),
        .pending  (pending)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Abort a hung run.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic sched_in_t make_cmd(input logic op, input logic [7:0] id,
                                           input logic [15:0] burst);
        sched_in_t c;
        c.op = op;
        c.job_id = id;
        c.burst = burst;
        return c;
    endfunction

    // Random command. Bursts lean toward values just above the quantum so that jobs get
    // demoted with equal remainders, which exercises tie breaking in the shortest-job level.
    function automatic sched_in_t random_cmd(input int submit_pct, input logic [15:0] q);
        sched_in_t c;
        int        sel;
        int        b;
        c.op = ($urandom_range(99) < submit_pct) ? OP_SUBMIT : OP_DISPATCH;
        c.job_id = 8'($urandom_range(255));
        sel = $urandom_range(9);
        if (sel < 2)
            b = $urandom_range(65535);
        else if (sel < 3)
            b = $urandom_range(1) ? 65535 : 0;
        else if (sel < 6)
            b = q + $urandom_range(1, 3);
        else
            b = $urandom_range(40);
        if (b > 65535)
            b = 65535;
        c.burst = 16'(b);
        return c;
    endfunction

    // Offer one item and hold it until the block takes it. Idle first at random unless
    // calm is set; the gap after an acceptance lands while the block is still working.
    task automatic send_item(input sched_in_t c);
        while (!calm && $urandom_range(99) < 18) begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        cmd <= c;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        if (c.op == OP_SUBMIT)
            n_submit++;
        else
            n_dispatch++;
    endtask

    // Drop start and wait until every predicted result has come back.
    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0 || busy !== 1'b0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_quantum(input logic [15:0] q);
        settle();
        cfg_we <= 1'b1;
        cfg_data <= q;
        @(posedge clk);
        cfg_we <= 1'b0;
        n_quanta++;
    endtask

    // A phase of random items; the submit share is drawn anew every 25 items so the levels
    // at times fill up to the reject point and at times drain down to empty dispatches.
    task automatic random_phase(input int count, input logic [15:0] q);
        int pct;
        pct = 50;
        for (int i = 0; i < count; i++) begin
            if (i % 25 == 0)
                case ($urandom_range(2))
                    0: pct = 25;
                    1: pct = 50;
                    default: pct = 80;
                endcase
            send_item(random_cmd(pct, q));
        end
    endtask

    initial begin
        logic [15:0] q;
        n_submit = 0;
        n_dispatch = 0;
        n_quanta = 1;
        calm = 1'b0;
        rst_n <= 1'b0;
        start <= 1'b0;
        cmd <= '0;
        cfg_we <= 1'b0;
        cfg_data <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, reset quantum of 4.
        // Dispatch with both levels empty.
        send_item(make_cmd(OP_DISPATCH, 8'h00, 16'h0000));
        // Field extremes, a zero burst and two jobs that demote with equal remainders.
        send_item(make_cmd(OP_SUBMIT, 8'h00, 16'h0000));
        send_item(make_cmd(OP_SUBMIT, 8'hFF, 16'hFFFF));
        send_item(make_cmd(OP_SUBMIT, 8'hA5, 16'd10));
        send_item(make_cmd(OP_SUBMIT, 8'h5A, 16'd10));
        // Zero burst finishes at once; the other three demote.
        repeat (4) send_item(make_cmd(OP_DISPATCH, 8'hFF, 16'hFFFF));
        // Fill both levels to the limit; the last submit must be rejected.
        for (int i = 0; i < 14; i++)
            send_item(make_cmd(OP_SUBMIT, 8'(16 + i), 16'($urandom_range(1, 12))));
        // Two round-robin slices with both levels full behind them.
        repeat (2) send_item(make_cmd(OP_DISPATCH, 8'h00, 16'h0000));

        // Random phases over several quanta: reset value, the extremes and in between.
        random_phase(PHASE_ITEMS, QUANTUM_RESET);
        set_quantum(16'd1);
        random_phase(PHASE_ITEMS, 16'd1);
        set_quantum(16'd0);
        random_phase(PHASE_ITEMS, 16'd0);
        set_quantum(16'hFFFF);
        random_phase(PHASE_ITEMS, 16'hFFFF);
        q = 16'($urandom_range(2, 12));
        set_quantum(q);
        calm = 1'b1;                    // a long stretch with no idling at all
        random_phase(PHASE_ITEMS, q);
        calm = 1'b0;
        set_quantum(QUANTUM_RESET);
        random_phase(PHASE_ITEMS, QUANTUM_RESET);

        settle();
        repeat (40) @(posedge clk);
        $display("covered %0d submits and %0d dispatches under %0d quantum settings",
                 n_submit, n_dispatch, n_quanta);
        $display("%0d results checked, zero and full quantum, full store, ties, empty levels",
                 checked);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

### filelist.f
sv/mfs_pkg.sv
sv/mfs_job_ram.sv
sv/multilevel_feedback_scheduler.sv
verif/schedule_checker.sv
verif/tb.sv
